>>> sv/kmsg_pkg.sv
// Shared types, constants and address helpers for the keyed min-score grid aggregator.
// Stands alone; kmsg_decide, the top level and the bench use it by scoped names.
`timescale 1ns / 1ps

package kmsg_pkg;

  localparam int MAX_CODONS    = 32;
  localparam int CODON_CHOICES = 6;
  localparam int GRID_CELLS    = 36;
  localparam int NUC_PER_CODON = 3;
  localparam int NUM_KEYS      = NUC_PER_CODON * MAX_CODONS;
  localparam int NUM_CELLS     = NUM_KEYS * GRID_CELLS;
  localparam int KEY_W         = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int ADDR_W        = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;

  localparam int OP_W      = 2;
  localparam int CODON_W   = 5;
  localparam int OFFSET_W  = 2;
  localparam int CHOICE_W  = 3;
  localparam int ENERGY_W  = 24;
  localparam int ADAPT_W   = 16;
  localparam int SCORE_W   = 32;
  localparam int STATE_W   = 16;
  localparam int VARIANT_W = 8;
  localparam int STATUS_W  = 3;
  localparam int FILLED_W  = 12;
  localparam int COUNT_W   = 32;
  localparam int KEYS_W    = 7;

  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_INSERTED    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_KEPT        = 3'd1;
  localparam logic [STATUS_W-1:0] ST_OVERWRITTEN = 3'd2;
  localparam logic [STATUS_W-1:0] ST_SKIPPED     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_READ        = 3'd4;
  localparam logic [STATUS_W-1:0] ST_CLEARED     = 3'd5;

  typedef struct packed {
    logic [OP_W-1:0]      op;
    logic [CODON_W-1:0]   codon;
    logic [OFFSET_W-1:0]  offset;
    logic [CHOICE_W-1:0]  first;
    logic [CHOICE_W-1:0]  second;
    logic [ENERGY_W-1:0]  energy;
    logic [ADAPT_W-1:0]   adapt;
    logic [SCORE_W-1:0]   score;
    logic                 finite;
    logic [STATE_W-1:0]   state;
    logic [VARIANT_W-1:0] variant;
  } item_t;

  typedef struct packed {
    logic                 filled;
    logic [SCORE_W-1:0]   score;
    logic [ENERGY_W-1:0]  energy;
    logic [ADAPT_W-1:0]   adapt;
    logic [STATE_W-1:0]   state;
    logic [VARIANT_W-1:0] variant;
  } cell_t;

  typedef struct packed {
    logic                do_write;
    logic                key_set;
    logic                filled_inc;
    logic                coll_inc;
    logic                over_inc;
    logic                show;
    logic [STATUS_W-1:0] status;
    cell_t               hit;
    cell_t               wdata;
  } dec_t;

  function automatic logic pos_ok(logic [CODON_W-1:0] c, logic [OFFSET_W-1:0] o);
    return (int'(c) < MAX_CODONS) && (int'(o) < NUC_PER_CODON);
  endfunction

  function automatic logic cell_ok(logic [CHOICE_W-1:0] x, logic [CHOICE_W-1:0] y);
    return (int'(x) < CODON_CHOICES) && (int'(y) < CODON_CHOICES) &&
           (int'(x) * CODON_CHOICES + int'(y) < GRID_CELLS);
  endfunction

  function automatic logic [KEY_W-1:0] key_of(logic [CODON_W-1:0] c,
                                             logic [OFFSET_W-1:0] o);
    if (!pos_ok(c, o)) begin
      return '0;
    end
    return KEY_W'(int'(c) * NUC_PER_CODON + int'(o));
  endfunction

  function automatic logic [ADDR_W-1:0] addr_of(logic [CODON_W-1:0] c,
                                               logic [OFFSET_W-1:0] o,
                                               logic [CHOICE_W-1:0] x,
                                               logic [CHOICE_W-1:0] y);
    if (!(pos_ok(c, o) && cell_ok(x, y))) begin
      return '0;
    end
    return ADDR_W'(int'(key_of(c, o)) * GRID_CELLS + int'(x) * CODON_CHOICES + int'(y));
  endfunction

endpackage

>>> sv/kmsg_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module kmsg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic                             re,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> sv/kmsg_decide.sv
// Insert/read decision on one fetched cell: outcome status, write-back word and counter bumps.
// Depends on kmsg_pkg.
`timescale 1ns / 1ps

module kmsg_decide (
  input  kmsg_pkg::item_t item_i,
  input  kmsg_pkg::cell_t cell_i,
  input  logic            key_used_i,
  output kmsg_pkg::dec_t  dec_o
);

  logic            pos;
  logic            cel;
  kmsg_pkg::cell_t newc;

  always_comb begin
    pos = kmsg_pkg::pos_ok(item_i.codon, item_i.offset);
    cel = kmsg_pkg::cell_ok(item_i.first, item_i.second);
    newc.filled  = 1'b1;
    newc.score   = item_i.score;
    newc.energy  = item_i.energy;
    newc.adapt   = item_i.adapt;
    newc.state   = item_i.state;
    newc.variant = item_i.variant;

    dec_o        = '0;
    dec_o.status = kmsg_pkg::ST_SKIPPED;
    dec_o.wdata  = newc;

    case (item_i.op)
      kmsg_pkg::OP_INSERT: begin
        if (pos) begin
          dec_o.key_set = !key_used_i;
          if (cel && item_i.finite) begin
            dec_o.show = 1'b1;
            if (!cell_i.filled) begin
              dec_o.do_write   = 1'b1;
              dec_o.filled_inc = 1'b1;
              dec_o.status     = kmsg_pkg::ST_INSERTED;
              dec_o.hit        = newc;
            end else begin
              dec_o.coll_inc = 1'b1;
              if ($signed(item_i.score) < $signed(cell_i.score)) begin
                dec_o.do_write = 1'b1;
                dec_o.over_inc = 1'b1;
                dec_o.status   = kmsg_pkg::ST_OVERWRITTEN;
                dec_o.hit      = newc;
              end else begin
                dec_o.status = kmsg_pkg::ST_KEPT;
                dec_o.hit    = cell_i;
              end
            end
          end
        end
      end
      kmsg_pkg::OP_READ: begin
        dec_o.status = kmsg_pkg::ST_READ;
        if (pos && cel && cell_i.filled) begin
          dec_o.show = 1'b1;
          dec_o.hit  = cell_i;
        end
      end
      default: begin
        dec_o.status = kmsg_pkg::ST_SKIPPED;
      end
    endcase
  end

endmodule

>>> sv/keyed_min_score_grid_aggregator.sv
// Keyed min-score grid aggregator: sequencer, cell RAM, key marks, counters and output register.
// Depends on kmsg_pkg, kmsg_ram and kmsg_decide.
`timescale 1ns / 1ps

// Each insert, read or unused op uses the single read-modify-write path: the accepting cycle
// reads the cell RAM, then the S_DECIDE state decides, writes the cell back and loads the
// output register once that register is free; no new beat is accepted until then. A clear
// zeroes the counters and key marks at once, then sweeps the filled marks of all 3456 cells,
// one per cycle, before it reports; no beat is accepted during the sweep. The same sweep
// runs after reset, without a report. A result waiting in the output register does not
// block the next accept, only the following write-back.
module keyed_min_score_grid_aggregator (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [kmsg_pkg::OP_W-1:0]             in_op,
  input  logic [kmsg_pkg::CODON_W-1:0]          in_codon_index,
  input  logic [kmsg_pkg::OFFSET_W-1:0]         in_nuc_offset,
  input  logic [kmsg_pkg::CHOICE_W-1:0]         in_first_codon,
  input  logic [kmsg_pkg::CHOICE_W-1:0]         in_second_codon,
  input  logic signed [kmsg_pkg::ENERGY_W-1:0]  in_free_energy,
  input  logic [kmsg_pkg::ADAPT_W-1:0]          in_adaptation_index,
  input  logic signed [kmsg_pkg::SCORE_W-1:0]   in_combined_score,
  input  logic                                  in_score_finite,
  input  logic [kmsg_pkg::STATE_W-1:0]          in_source_state,
  input  logic [kmsg_pkg::VARIANT_W-1:0]        in_variant_index,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [kmsg_pkg::STATUS_W-1:0]         out_status,
  output logic                                  out_hit_valid,
  output logic signed [kmsg_pkg::ENERGY_W-1:0]  out_hit_energy,
  output logic [kmsg_pkg::ADAPT_W-1:0]          out_hit_adaptation,
  output logic signed [kmsg_pkg::SCORE_W-1:0]   out_hit_score,
  output logic [kmsg_pkg::STATE_W-1:0]          out_hit_state,
  output logic [kmsg_pkg::VARIANT_W-1:0]        out_hit_variant,
  output logic [kmsg_pkg::FILLED_W-1:0]         out_populated_count,
  output logic [kmsg_pkg::COUNT_W-1:0]          out_collision_count,
  output logic [kmsg_pkg::COUNT_W-1:0]          out_overwrite_count,
  output logic [kmsg_pkg::KEYS_W-1:0]           out_key_count
);

  typedef enum logic [3:0] {
    S_IDLE     = 4'b0001,
    S_DECIDE   = 4'b0010,
    S_SWEEP    = 4'b0100,
    S_CLR_DONE = 4'b1000
  } state_t;

  state_t                             state_r, state_nxt;
  kmsg_pkg::item_t                    item_r, item_nxt;
  logic [kmsg_pkg::ADDR_W-1:0]        sweep_r, sweep_nxt;
  logic                               report_r, report_nxt;
  logic [kmsg_pkg::NUM_KEYS-1:0]      key_used_r, key_used_nxt;
  logic [kmsg_pkg::FILLED_W-1:0]      filled_r, filled_nxt;
  logic [kmsg_pkg::COUNT_W-1:0]       coll_r, coll_nxt;
  logic [kmsg_pkg::COUNT_W-1:0]       over_r, over_nxt;
  logic [kmsg_pkg::KEYS_W-1:0]        keys_r, keys_nxt;
  logic                               out_valid_r, out_valid_nxt;
  logic                               load;
  logic                               out_free;
  logic                               accept;

  logic                               ram_we;
  logic [kmsg_pkg::ADDR_W-1:0]        ram_waddr;
  kmsg_pkg::cell_t                    ram_wdata;
  logic                               ram_re;
  logic [kmsg_pkg::ADDR_W-1:0]        ram_raddr;
  kmsg_pkg::cell_t                    ram_rdata;

  logic [kmsg_pkg::KEY_W-1:0]         key;
  kmsg_pkg::dec_t                     dec;

  kmsg_ram #(
    .WIDTH($bits(kmsg_pkg::cell_t)),
    .DEPTH(kmsg_pkg::NUM_CELLS)
  ) u_cells (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign key = kmsg_pkg::key_of(item_r.codon, item_r.offset);

  kmsg_decide u_decide (
    .item_i    (item_r),
    .cell_i    (ram_rdata),
    .key_used_i(key_used_r[key]),
    .dec_o     (dec)
  );

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  assign ram_re    = accept && (in_op != kmsg_pkg::OP_CLEAR);
  assign ram_raddr = kmsg_pkg::addr_of(in_codon_index, in_nuc_offset,
                                       in_first_codon, in_second_codon);

  always_comb begin
    item_nxt.op      = in_op;
    item_nxt.codon   = in_codon_index;
    item_nxt.offset  = in_nuc_offset;
    item_nxt.first   = in_first_codon;
    item_nxt.second  = in_second_codon;
    item_nxt.energy  = in_free_energy;
    item_nxt.adapt   = in_adaptation_index;
    item_nxt.score   = in_combined_score;
    item_nxt.finite  = in_score_finite;
    item_nxt.state   = in_source_state;
    item_nxt.variant = in_variant_index;
  end

  always_comb begin
    state_nxt     = state_r;
    sweep_nxt     = sweep_r;
    report_nxt    = report_r;
    key_used_nxt  = key_used_r;
    filled_nxt    = filled_r;
    coll_nxt      = coll_r;
    over_nxt      = over_r;
    keys_nxt      = keys_r;
    load          = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = sweep_r;
    ram_wdata     = '0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_op == kmsg_pkg::OP_CLEAR) begin
            key_used_nxt = '0;
            filled_nxt   = '0;
            coll_nxt     = '0;
            over_nxt     = '0;
            keys_nxt     = '0;
            report_nxt   = 1'b1;
            sweep_nxt    = '0;
            state_nxt    = S_SWEEP;
          end else begin
            state_nxt = S_DECIDE;
          end
        end
      end
      S_DECIDE: begin
        if (out_free) begin
          load      = 1'b1;
          ram_we    = dec.do_write;
          ram_waddr = kmsg_pkg::addr_of(item_r.codon, item_r.offset,
                                        item_r.first, item_r.second);
          ram_wdata = dec.wdata;
          if (dec.key_set) begin
            key_used_nxt[key] = 1'b1;
            if (!(&keys_r)) begin
              keys_nxt = keys_r + 1'b1;
            end
          end
          if (dec.filled_inc && !(&filled_r)) begin
            filled_nxt = filled_r + 1'b1;
          end
          if (dec.coll_inc && !(&coll_r)) begin
            coll_nxt = coll_r + 1'b1;
          end
          if (dec.over_inc && !(&over_r)) begin
            over_nxt = over_r + 1'b1;
          end
          state_nxt = S_IDLE;
        end
      end
      S_SWEEP: begin
        ram_we = 1'b1;
        if (sweep_r == kmsg_pkg::ADDR_W'(kmsg_pkg::NUM_CELLS - 1)) begin
          state_nxt = report_r ? S_CLR_DONE : S_IDLE;
        end else begin
          sweep_nxt = sweep_r + 1'b1;
        end
      end
      S_CLR_DONE: begin
        if (out_free) begin
          load       = 1'b1;
          report_nxt = 1'b0;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_SWEEP;
      sweep_r     <= '0;
      report_r    <= 1'b0;
      key_used_r  <= '0;
      filled_r    <= '0;
      coll_r      <= '0;
      over_r      <= '0;
      keys_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sweep_r     <= sweep_nxt;
      report_r    <= report_nxt;
      key_used_r  <= key_used_nxt;
      filled_r    <= filled_nxt;
      coll_r      <= coll_nxt;
      over_r      <= over_nxt;
      keys_r      <= keys_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= item_nxt;
    end
    if (load) begin
      out_status          <= (state_r == S_CLR_DONE) ? kmsg_pkg::ST_CLEARED : dec.status;
      out_hit_valid       <= (state_r == S_CLR_DONE) ? 1'b0 : dec.show;
      out_hit_energy      <= (state_r == S_CLR_DONE) ? '0 : dec.hit.energy;
      out_hit_adaptation  <= (state_r == S_CLR_DONE) ? '0 : dec.hit.adapt;
      out_hit_score       <= (state_r == S_CLR_DONE) ? '0 : dec.hit.score;
      out_hit_state       <= (state_r == S_CLR_DONE) ? '0 : dec.hit.state;
      out_hit_variant     <= (state_r == S_CLR_DONE) ? '0 : dec.hit.variant;
      out_populated_count <= filled_nxt;
      out_collision_count <= coll_nxt;
      out_overwrite_count <= over_nxt;
      out_key_count       <= keys_nxt;
    end
  end

`ifndef SYNTHESIS
  a_over_le_coll: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_overwrite_count <= out_collision_count))
    else $error("overwrite count exceeds collision count");

  a_populated_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (int'(out_populated_count) <= kmsg_pkg::NUM_CELLS))
    else $error("populated count beyond cell total");

  a_clear_sweeps: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_op == kmsg_pkg::OP_CLEAR) |=>
      (state_r == S_SWEEP && coll_r == '0 && key_used_r == '0))
    else $error("clear did not start a sweep with zeroed state");

  a_decide_once: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DECIDE && out_free) |=> (state_r == S_IDLE && out_valid_r))
    else $error("decision did not retire into the output register");
`endif

endmodule

>>> sim/tb.sv
// Self-checking bench for keyed_min_score_grid_aggregator: directed corner beats, then
// random insert/read/clear/spare-op traffic with bursty idling on both channels.
// Depends on kmsg_pkg for widths, op and status codes; a grid mirror class predicts results.
`timescale 1ns / 1ps

module tb;

  localparam int STALL_LIMIT = 20000;
  localparam int RANDOM_BEATS = 1000;
  localparam logic [kmsg_pkg::OP_W-1:0] OP_SPARE = 2'd3;

  typedef struct packed {
    logic [kmsg_pkg::STATUS_W-1:0]  status;
    logic                           hit_valid;
    logic [kmsg_pkg::ENERGY_W-1:0]  energy;
    logic [kmsg_pkg::ADAPT_W-1:0]   adapt;
    logic [kmsg_pkg::SCORE_W-1:0]   score;
    logic [kmsg_pkg::STATE_W-1:0]   state;
    logic [kmsg_pkg::VARIANT_W-1:0] variant;
    logic [kmsg_pkg::FILLED_W-1:0]  populated;
    logic [kmsg_pkg::COUNT_W-1:0]   collisions;
    logic [kmsg_pkg::COUNT_W-1:0]   overwrites;
    logic [kmsg_pkg::KEYS_W-1:0]    keys;
  } grid_result_t;

  class grid_mirror;
    bit                             filled [kmsg_pkg::NUM_CELLS];
    logic [kmsg_pkg::SCORE_W-1:0]   best   [kmsg_pkg::NUM_CELLS];
    logic [kmsg_pkg::ENERGY_W-1:0]  energy [kmsg_pkg::NUM_CELLS];
    logic [kmsg_pkg::ADAPT_W-1:0]   adapt  [kmsg_pkg::NUM_CELLS];
    logic [kmsg_pkg::STATE_W-1:0]   origin [kmsg_pkg::NUM_CELLS];
    logic [kmsg_pkg::VARIANT_W-1:0] variant[kmsg_pkg::NUM_CELLS];
    bit                             key_seen[kmsg_pkg::NUM_KEYS];
    logic [kmsg_pkg::FILLED_W-1:0]  populated;
    logic [kmsg_pkg::COUNT_W-1:0]   collisions;
    logic [kmsg_pkg::COUNT_W-1:0]   overwrites;
    logic [kmsg_pkg::KEYS_W-1:0]    keys;
    grid_result_t                   awaited[$];
    int unsigned                    failures;

    function void wipe();
      foreach (filled[i]) filled[i] = 1'b0;
      foreach (key_seen[i]) key_seen[i] = 1'b0;
      populated  = '0;
      collisions = '0;
      overwrites = '0;
      keys       = '0;
    endfunction

    function new();
      wipe();
      failures = 0;
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction

    function void note_beat(kmsg_pkg::item_t it);
      grid_result_t r;
      bit pos_good, cell_good, show;
      int key, addr;
      r = '0;
      r.status = kmsg_pkg::ST_SKIPPED;
      show = 1'b0;
      pos_good = int'(it.codon) < kmsg_pkg::MAX_CODONS &&
                 int'(it.offset) < kmsg_pkg::NUC_PER_CODON;
      cell_good = int'(it.first) < kmsg_pkg::CODON_CHOICES &&
                  int'(it.second) < kmsg_pkg::CODON_CHOICES &&
                  int'(it.first) * kmsg_pkg::CODON_CHOICES + int'(it.second) <
                  kmsg_pkg::GRID_CELLS;
      key = int'(it.codon) * kmsg_pkg::NUC_PER_CODON + int'(it.offset);
      addr = (pos_good && cell_good) ?
             key * kmsg_pkg::GRID_CELLS + int'(it.first) * kmsg_pkg::CODON_CHOICES +
             int'(it.second) : 0;
      case (it.op)
        kmsg_pkg::OP_CLEAR: begin
          wipe();
          r.status = kmsg_pkg::ST_CLEARED;
        end
        kmsg_pkg::OP_INSERT: begin
          if (pos_good) begin
            if (!key_seen[key]) begin
              key_seen[key] = 1'b1;
              if (keys != '1) keys++;
            end
            if (cell_good && it.finite) begin
              bit take;
              take = 1'b0;
              if (!filled[addr]) begin
                take = 1'b1;
                filled[addr] = 1'b1;
                if (populated != '1) populated++;
                r.status = kmsg_pkg::ST_INSERTED;
              end else begin
                if (collisions != '1) collisions++;
                if ($signed(it.score) < $signed(best[addr])) begin
                  take = 1'b1;
                  if (overwrites != '1) overwrites++;
                  r.status = kmsg_pkg::ST_OVERWRITTEN;
                end else begin
                  r.status = kmsg_pkg::ST_KEPT;
                end
              end
              if (take) begin
                best[addr]    = it.score;
                energy[addr]  = it.energy;
                adapt[addr]   = it.adapt;
                origin[addr]  = it.state;
                variant[addr] = it.variant;
              end
              show = 1'b1;
            end
          end
        end
        kmsg_pkg::OP_READ: begin
          r.status = kmsg_pkg::ST_READ;
          show = pos_good && cell_good && filled[addr];
        end
        default: ;
      endcase
      if (show) begin
        r.hit_valid = 1'b1;
        r.energy    = energy[addr];
        r.adapt     = adapt[addr];
        r.score     = best[addr];
        r.state     = origin[addr];
        r.variant   = variant[addr];
      end
      r.populated  = populated;
      r.collisions = collisions;
      r.overwrites = overwrites;
      r.keys       = keys;
      awaited.insert(awaited.size(), r);
    endfunction

    function void tally(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        failures++;
        $display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_beat(grid_result_t got);
      grid_result_t want;
      if (awaited.size() == 0) begin
        failures++;
        $display("%0t: result beat with none expected, actual status %0d", $time, got.status);
        return;
      end
      want = awaited.pop_front();
      tally("status", want.status, got.status);
      tally("hit_valid", want.hit_valid, got.hit_valid);
      tally("hit_energy", want.energy, got.energy);
      tally("hit_adaptation", want.adapt, got.adapt);
      tally("hit_score", want.score, got.score);
      tally("hit_state", want.state, got.state);
      tally("hit_variant", want.variant, got.variant);
      tally("populated_count", want.populated, got.populated);
      tally("collision_count", want.collisions, got.collisions);
      tally("overwrite_count", want.overwrites, got.overwrites);
      tally("key_count", want.keys, got.keys);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [kmsg_pkg::OP_W-1:0] in_op = kmsg_pkg::OP_CLEAR;
  logic [kmsg_pkg::CODON_W-1:0] in_codon_index = '0;
  logic [kmsg_pkg::OFFSET_W-1:0] in_nuc_offset = '0;
  logic [kmsg_pkg::CHOICE_W-1:0] in_first_codon = '0;
  logic [kmsg_pkg::CHOICE_W-1:0] in_second_codon = '0;
  logic signed [kmsg_pkg::ENERGY_W-1:0] in_free_energy = '0;
  logic [kmsg_pkg::ADAPT_W-1:0] in_adaptation_index = '0;
  logic signed [kmsg_pkg::SCORE_W-1:0] in_combined_score = '0;
  logic in_score_finite = 1'b0;
  logic [kmsg_pkg::STATE_W-1:0] in_source_state = '0;
  logic [kmsg_pkg::VARIANT_W-1:0] in_variant_index = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [kmsg_pkg::STATUS_W-1:0] out_status;
  logic out_hit_valid;
  logic signed [kmsg_pkg::ENERGY_W-1:0] out_hit_energy;
  logic [kmsg_pkg::ADAPT_W-1:0] out_hit_adaptation;
  logic signed [kmsg_pkg::SCORE_W-1:0] out_hit_score;
  logic [kmsg_pkg::STATE_W-1:0] out_hit_state;
  logic [kmsg_pkg::VARIANT_W-1:0] out_hit_variant;
  logic [kmsg_pkg::FILLED_W-1:0] out_populated_count;
  logic [kmsg_pkg::COUNT_W-1:0] out_collision_count;
  logic [kmsg_pkg::COUNT_W-1:0] out_overwrite_count;
  logic [kmsg_pkg::KEYS_W-1:0] out_key_count;

  grid_mirror      mirror = new();
  int unsigned     idle_pct = 0;
  bit              calm = 1'b0;
  int unsigned     hold_left = 0;
  int unsigned     stall_cycles = 0;
  kmsg_pkg::item_t recent[$];
  kmsg_pkg::item_t directed[$];

  keyed_min_score_grid_aggregator u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_op              (in_op),
    .in_codon_index     (in_codon_index),
    .in_nuc_offset      (in_nuc_offset),
    .in_first_codon     (in_first_codon),
    .in_second_codon    (in_second_codon),
    .in_free_energy     (in_free_energy),
    .in_adaptation_index(in_adaptation_index),
    .in_combined_score  (in_combined_score),
    .in_score_finite    (in_score_finite),
    .in_source_state    (in_source_state),
    .in_variant_index   (in_variant_index),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_hit_valid      (out_hit_valid),
    .out_hit_energy     (out_hit_energy),
    .out_hit_adaptation (out_hit_adaptation),
    .out_hit_score      (out_hit_score),
    .out_hit_state      (out_hit_state),
    .out_hit_variant    (out_hit_variant),
    .out_populated_count(out_populated_count),
    .out_collision_count(out_collision_count),
    .out_overwrite_count(out_overwrite_count),
    .out_key_count      (out_key_count)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      mirror.note_beat(kmsg_pkg::item_t'{in_op, in_codon_index, in_nuc_offset,
                                         in_first_codon, in_second_codon, in_free_energy,
                                         in_adaptation_index, in_combined_score,
                                         in_score_finite, in_source_state,
                                         in_variant_index});
    end
    if (rst_n && out_valid && out_ready) begin
      mirror.check_beat(grid_result_t'{out_status, out_hit_valid, out_hit_energy,
                                       out_hit_adaptation, out_hit_score, out_hit_state,
                                       out_hit_variant, out_populated_count,
                                       out_collision_count, out_overwrite_count,
                                       out_key_count});
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Stall the result side in bursts of random length.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!calm && $urandom_range(0, 99) < idle_pct) begin
      out_ready <= 1'b0;
      hold_left <= $urandom_range(0, 7);
    end else begin
      out_ready <= 1'b1;
    end
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("CHECK FAILED");
    $finish;
  end

  function automatic kmsg_pkg::item_t compose(logic [kmsg_pkg::OP_W-1:0] op, int codon,
                                              int offset, int x, int y,
                                              logic [kmsg_pkg::SCORE_W-1:0] score,
                                              bit finite);
    kmsg_pkg::item_t it;
    it.op      = op;
    it.codon   = kmsg_pkg::CODON_W'(codon);
    it.offset  = kmsg_pkg::OFFSET_W'(offset);
    it.first   = kmsg_pkg::CHOICE_W'(x);
    it.second  = kmsg_pkg::CHOICE_W'(y);
    it.energy  = kmsg_pkg::ENERGY_W'($urandom);
    it.adapt   = kmsg_pkg::ADAPT_W'($urandom);
    it.score   = score;
    it.finite  = finite;
    it.state   = kmsg_pkg::STATE_W'($urandom);
    it.variant = kmsg_pkg::VARIANT_W'($urandom);
    return it;
  endfunction

  function automatic void enlist(kmsg_pkg::item_t it);
    directed.insert(directed.size(), it);
  endfunction

  function automatic kmsg_pkg::item_t random_beat();
    kmsg_pkg::item_t it;
    int roll;
    roll = $urandom_range(0, 99);
    it = compose(kmsg_pkg::OP_INSERT, $urandom_range(0, 31), $urandom_range(0, 2),
                 $urandom_range(0, 5), $urandom_range(0, 5), $urandom, 1'b1);
    if (roll < 1) begin
      it.op = kmsg_pkg::OP_CLEAR;
    end else if (roll < 60) begin
      // Crowd inserts onto a few grids and cells so collisions are common.
      if ($urandom_range(0, 1) == 0) begin
        it.codon  = kmsg_pkg::CODON_W'($urandom_range(0, 3));
        it.first  = kmsg_pkg::CHOICE_W'($urandom_range(0, 1));
        it.second = kmsg_pkg::CHOICE_W'($urandom_range(0, 1));
      end
      if ($urandom_range(0, 2) == 0) begin
        it.score = kmsg_pkg::SCORE_W'($signed($urandom_range(0, 7)) - 4);
      end
    end else if (roll < 85) begin
      if (recent.size() != 0 && $urandom_range(0, 9) < 7) begin
        it = recent[$urandom_range(0, recent.size() - 1)];
      end
      it.op = kmsg_pkg::OP_READ;
    end else begin
      it.op     = kmsg_pkg::OP_W'($urandom_range(1, 3));
      it.offset = kmsg_pkg::OFFSET_W'($urandom);
      it.first  = kmsg_pkg::CHOICE_W'($urandom);
      it.second = kmsg_pkg::CHOICE_W'($urandom);
      it.finite = $urandom_range(0, 3) != 0;
    end
    if (it.op == kmsg_pkg::OP_INSERT) begin
      recent.insert(recent.size(), it);
      if (recent.size() > 48) void'(recent.pop_front());
    end
    return it;
  endfunction

  task automatic send_beat(kmsg_pkg::item_t it);
    if (!calm && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid            <= 1'b1;
    in_op               <= it.op;
    in_codon_index      <= it.codon;
    in_nuc_offset       <= it.offset;
    in_first_codon      <= it.first;
    in_second_codon     <= it.second;
    in_free_energy      <= it.energy;
    in_adaptation_index <= it.adapt;
    in_combined_score   <= it.score;
    in_score_finite     <= it.finite;
    in_source_state     <= it.state;
    in_variant_index    <= it.variant;
    do @(posedge clk); while (!in_ready);
  endtask

  // Hold the sender until every expected result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (mirror.pending() != 0);
  endtask

  initial begin
    kmsg_pkg::item_t it;
    int counted;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    enlist(compose(kmsg_pkg::OP_READ, 0, 0, 0, 0, '0, 1'b1));
    it = compose(kmsg_pkg::OP_INSERT, 0, 0, 0, 0, 32'h7FFF_FFFF, 1'b1);
    it.energy = 24'h7F_FFFF;
    it.adapt = '1;
    it.state = '1;
    it.variant = '1;
    enlist(it);
    enlist(compose(kmsg_pkg::OP_INSERT, 0, 0, 0, 0, 32'h7FFF_FFFF, 1'b1));
    it = compose(kmsg_pkg::OP_INSERT, 0, 0, 0, 0, 32'h8000_0000, 1'b1);
    it.energy = 24'h80_0000;
    it.adapt = '0;
    it.state = '0;
    it.variant = '0;
    enlist(it);
    enlist(compose(kmsg_pkg::OP_INSERT, 0, 0, 0, 0, 32'h0, 1'b1));
    enlist(compose(kmsg_pkg::OP_READ, 0, 0, 0, 0, '0, 1'b0));
    enlist(compose(kmsg_pkg::OP_INSERT, 31, 2, 5, 5, 32'hFFFF_FFFF, 1'b1));
    enlist(compose(kmsg_pkg::OP_READ, 31, 2, 5, 5, '0, 1'b1));
    enlist(compose(kmsg_pkg::OP_INSERT, 9, 3, 1, 1, 32'h1, 1'b1));
    enlist(compose(kmsg_pkg::OP_READ, 9, 3, 1, 1, '0, 1'b1));
    enlist(compose(kmsg_pkg::OP_INSERT, 5, 1, 6, 2, 32'h1, 1'b1));
    enlist(compose(kmsg_pkg::OP_INSERT, 6, 0, 1, 7, 32'h1, 1'b1));
    enlist(compose(kmsg_pkg::OP_INSERT, 7, 0, 2, 2, 32'h1, 1'b0));
    enlist(compose(kmsg_pkg::OP_READ, 7, 0, 2, 2, '0, 1'b1));
    enlist(compose(kmsg_pkg::OP_READ, 0, 0, 7, 7, '0, 1'b1));
    enlist(compose(OP_SPARE, 0, 0, 0, 0, '0, 1'b1));
    enlist(compose(kmsg_pkg::OP_CLEAR, 0, 0, 0, 0, '0, 1'b1));
    enlist(compose(kmsg_pkg::OP_READ, 0, 0, 0, 0, '0, 1'b1));
    enlist(compose(kmsg_pkg::OP_INSERT, 0, 0, 0, 0, 32'h5, 1'b1));
    enlist(compose(kmsg_pkg::OP_READ, 31, 2, 5, 5, '0, 1'b1));
    foreach (directed[i]) send_beat(directed[i]);
    drain();

    counted = 0;
    while (counted < RANDOM_BEATS) begin
      if (counted % 100 == 0) begin
        case ($urandom_range(0, 2))
          0: idle_pct = 0;
          1: idle_pct = 10;
          default: idle_pct = 35;
        endcase
      end
      calm = counted >= RANDOM_BEATS - 100;
      it = random_beat();
      send_beat(it);
      if (it.op != OP_SPARE) counted++;
      if (counted == RANDOM_BEATS / 2) begin
        drain();
        counted++;
      end
    end
    in_valid <= 1'b0;
    while (mirror.pending() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (mirror.failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> keyed_min_score_grid_aggregator.f
sv/kmsg_pkg.sv
sv/kmsg_ram.sv
sv/kmsg_decide.sv
sv/keyed_min_score_grid_aggregator.sv
sim/tb.sv
